// File: hdl/alt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants for the array list table
// Operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package alt_pkg;

  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int AW      = POS_W;
  localparam int DEPTH   = 1 << POS_W;
  localparam int CW      = POS_W + 1;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_GET_WAIT,
    S_RM_CAP,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_SCAN,
    S_PUSH
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_APPEND,
    DP_SET,
    DP_RD_POS,
    DP_INIT_UP,
    DP_INIT_FIND,
    DP_SHIFT_DN,
    DP_SHIFT_UP,
    DP_SCAN,
    DP_INS_WORD,
    DP_REMOVE_END,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic              load;
    dp_op_t            op;
    logic              cap_word;
    logic              cap_found;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              push;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pos_ge_cnt;
    logic              pos_gt_cnt;
    logic              full;
    logic              ptr_lt_cnt;
    logic              ptr_gt_pos;
    logic              pend;
    logic              match;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/array_list_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_table: fixed-capacity ordered list of 32-bit words
// Append, insert, set, remove, get, find and clear on a 64-entry list.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  func, position, word_in
//   out      output     out_valid/out_stall  status, word_out, found_at,
//                                            count, is_empty
//
// One item at a time. Remove and insert shift the elements between the
// position and the count, and find walks from the start up to the match or
// the count, one element per cycle; a shift reads one element and writes
// another in the same cycle. Reset empties the list; no clearing pass. The
// output register holds a result under stall while the next item is taken.
// ----------------------------------------------------------------------------
module array_list_table
  import alt_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [FUNC_W-1:0]          func,
  input  wire logic [POS_W-1:0]           position,
  input  wire logic signed [WORD_W-1:0]   word_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [STAT_W-1:0]               status,
  output logic signed [WORD_W-1:0]        word_out,
  output logic [POS_W-1:0]                found_at,
  output logic [CW-1:0]                   count,
  output logic                            is_empty
);

  cmd_t              cmd;
  stat_t             stat;
  logic [WORD_W-1:0] word_out_u;

  alt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  alt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .position  (position),
    .word_in   (word_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .word_out  (word_out_u),
    .found_at  (found_at),
    .count     (count),
    .is_empty  (is_empty)
  );

  assign word_out = $signed(word_out_u);

endmodule

`default_nettype wire

// File: hdl/alt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_ctrl: operation sequencer
// Decodes each item, steps the shift and search walks, hands off the result.
// ----------------------------------------------------------------------------
module alt_ctrl
  import alt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_PUSH;
        case (stat.func)
          FN_INSERT: if (!stat.pos_gt_cnt && !stat.full) state_next = S_SHIFT_UP;
          FN_REMOVE: if (!stat.pos_ge_cnt) state_next = S_RM_CAP;
          FN_GET:    if (!stat.pos_ge_cnt) state_next = S_GET_WAIT;
          FN_FIND:   state_next = S_SCAN;
          default:   state_next = S_PUSH;
        endcase
      end
      S_GET_WAIT: state_next = S_PUSH;
      S_RM_CAP:   state_next = S_SHIFT_DN;
      S_SHIFT_DN: begin
        if (!stat.ptr_lt_cnt && !stat.pend) state_next = S_PUSH;
      end
      S_SHIFT_UP: begin
        if (!stat.ptr_gt_pos && !stat.pend) state_next = S_PUSH;
      end
      S_SCAN: begin
        if (stat.match || (!stat.ptr_lt_cnt && !stat.pend)) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = DP_NONE;
    cmd.status     = ST_OK;
    in_stall       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        unique case (stat.func)
          FN_APPEND: begin
            if (stat.full) cmd.status = ST_FULL;
            else           cmd.op     = DP_APPEND;
          end
          FN_INSERT: begin
            if (stat.pos_gt_cnt) cmd.status = ST_RANGE;
            else if (stat.full)  cmd.status = ST_FULL;
            else                 cmd.op     = DP_INIT_UP;
          end
          FN_SET: begin
            if (stat.pos_ge_cnt) cmd.status = ST_RANGE;
            else                 cmd.op     = DP_SET;
          end
          FN_REMOVE, FN_GET: begin
            if (stat.pos_ge_cnt) cmd.status = ST_RANGE;
            else                 cmd.op     = DP_RD_POS;
          end
          FN_FIND: begin
            cmd.status = ST_NOTFOUND;
            cmd.op     = DP_INIT_FIND;
          end
          FN_CLEAR: cmd.op = DP_CLEAR;
          default:  cmd.op = DP_NONE;
        endcase
      end
      S_GET_WAIT: begin
        cmd.cap_word = 1'b1;
      end
      S_RM_CAP: begin
        cmd.cap_word = 1'b1;
        cmd.op       = DP_SHIFT_DN;
      end
      S_SHIFT_DN: begin
        if (!stat.ptr_lt_cnt && !stat.pend) cmd.op = DP_REMOVE_END;
        else                                cmd.op = DP_SHIFT_DN;
      end
      S_SHIFT_UP: begin
        if (!stat.ptr_gt_pos && !stat.pend) cmd.op = DP_INS_WORD;
        else                                cmd.op = DP_SHIFT_UP;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.cap_found  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end else if (stat.ptr_lt_cnt || stat.pend) begin
          cmd.op = DP_SCAN;
        end
      end
      S_PUSH: begin
        cmd.push = stat.out_free;
      end
      default: cmd.op = DP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/alt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_dp: list storage and result datapath
// Element memory, count, walk pointer, result staging and output register.
// ----------------------------------------------------------------------------
module alt_dp
  import alt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic [WORD_W-1:0]   word_in,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [WORD_W-1:0]        word_out,
  output logic [POS_W-1:0]         found_at,
  output logic [CW-1:0]            count,
  output logic                     is_empty
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [FUNC_W-1:0] op_func;
  logic [AW-1:0]     op_pos;
  logic [WORD_W-1:0] op_word;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     ptr;
  logic [AW-1:0]     wa;
  logic              pend;
  logic [WORD_W-1:0] rd_data;
  logic [STAT_W-1:0] res_status;
  logic [WORD_W-1:0] res_word;
  logic [POS_W-1:0]  res_found;

  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     ptr_m1;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign pos_c  = {1'b0, op_pos};
  assign ptr_m1 = ptr - CW'(1);

  always_comb begin
    stat.func       = op_func;
    stat.pos_ge_cnt = (pos_c >= cnt);
    stat.pos_gt_cnt = (pos_c > cnt);
    stat.full       = (cnt == CW'(DEPTH));
    stat.ptr_lt_cnt = (ptr < cnt);
    stat.ptr_gt_pos = (ptr > pos_c);
    stat.pend       = pend;
    stat.match      = pend && (rd_data == op_word);
    stat.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = op_pos;
    wr_en   = 1'b0;
    wr_addr = op_pos;
    wr_data = op_word;
    case (cmd.op)
      DP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = cnt[AW-1:0];
      end
      DP_SET, DP_INS_WORD: begin
        wr_en = 1'b1;
      end
      DP_RD_POS: begin
        rd_en = 1'b1;
      end
      DP_SHIFT_DN: begin
        rd_en   = stat.ptr_lt_cnt;
        rd_addr = ptr[AW-1:0];
        wr_en   = pend;
        wr_addr = wa;
        wr_data = rd_data;
      end
      DP_SHIFT_UP: begin
        rd_en   = stat.ptr_gt_pos;
        rd_addr = ptr_m1[AW-1:0];
        wr_en   = pend;
        wr_addr = wa;
        wr_data = rd_data;
      end
      DP_SCAN: begin
        rd_en   = stat.ptr_lt_cnt;
        rd_addr = ptr[AW-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_pos  <= position;
      op_word <= word_in;
    end
    case (cmd.op)
      DP_RD_POS: ptr <= pos_c + CW'(1);
      DP_INIT_UP: ptr <= cnt;
      DP_INIT_FIND: ptr <= '0;
      DP_SHIFT_DN: begin
        if (stat.ptr_lt_cnt) begin
          ptr <= ptr + CW'(1);
          wa  <= ptr_m1[AW-1:0];
        end
      end
      DP_SHIFT_UP: begin
        if (stat.ptr_gt_pos) begin
          ptr <= ptr_m1;
          wa  <= ptr[AW-1:0];
        end
      end
      DP_SCAN: begin
        if (stat.ptr_lt_cnt) begin
          ptr <= ptr + CW'(1);
          wa  <= ptr[AW-1:0];
        end
      end
      default: ptr <= ptr;
    endcase
    if (cmd.load) begin
      res_word  <= '0;
      res_found <= '0;
    end
    if (cmd.cap_word)   res_word   <= rd_data;
    if (cmd.cap_found)  res_found  <= wa;
    if (cmd.set_status) res_status <= cmd.status;
    if (cmd.push) begin
      status   <= res_status;
      word_out <= res_word;
      found_at <= res_found;
      count    <= cnt;
      is_empty <= (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        DP_APPEND, DP_INS_WORD: cnt <= cnt + CW'(1);
        DP_REMOVE_END:          cnt <= cnt - CW'(1);
        DP_CLEAR:               cnt <= '0;
        default:                cnt <= cnt;
      endcase
      case (cmd.op)
        DP_RD_POS, DP_INIT_UP, DP_INIT_FIND: pend <= 1'b0;
        DP_SHIFT_DN, DP_SCAN:                pend <= stat.ptr_lt_cnt;
        DP_SHIFT_UP:                         pend <= stat.ptr_gt_pos;
        default:                             pend <= pend;
      endcase
      if (cmd.push)         out_valid <= 1'b1;
      else if (!out_stall)  out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above capacity");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_APPEND || cmd.op == DP_INS_WORD) |=> cnt == $past(cnt) + CW'(1))
    else $error("count did not grow on append or insert");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_REMOVE_END |-> cnt != '0)
    else $error("remove finished on an empty list");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire

// File: dv/array_list_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_checker: result predictor and scoreboard for the list table
// Watches both channels of the block. Each accepted item is applied to a
// private copy of the list, and the result it must give is queued. Each
// accepted result is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module array_list_table_checker
  import alt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [POS_W-1:0]    position,
  input  logic [WORD_W-1:0]   word_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STAT_W-1:0]   status,
  input  logic [WORD_W-1:0]   word_out,
  input  logic [POS_W-1:0]    found_at,
  input  logic [CW-1:0]       count,
  input  logic                is_empty,
  output int                  errors,
  output int                  pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  found;
    logic [CW-1:0]     count;
    logic              empty;
  } list_result_t;

  logic [WORD_W-1:0] words [DEPTH];
  int                n_words = 0;
  list_result_t      due_q [$];
  int                err_n = 0;

  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] f,
                                                 input logic [POS_W-1:0]  p,
                                                 input logic [WORD_W-1:0] w);
    list_result_t r;
    int           i;
    r        = '0;
    r.status = ST_OK;
    case (f)
      FN_APPEND: begin
        if (n_words >= DEPTH) r.status = ST_FULL;
        else begin
          words[n_words] = w;
          n_words++;
        end
      end
      FN_INSERT: begin
        if (int'(p) > n_words) r.status = ST_RANGE;
        else if (n_words >= DEPTH) r.status = ST_FULL;
        else begin
          for (i = n_words; i > int'(p); i--) words[i] = words[i-1];
          words[p] = w;
          n_words++;
        end
      end
      FN_SET: begin
        if (int'(p) >= n_words) r.status = ST_RANGE;
        else words[p] = w;
      end
      FN_REMOVE: begin
        if (int'(p) >= n_words) r.status = ST_RANGE;
        else begin
          r.word = words[p];
          for (i = int'(p); i + 1 < n_words; i++) words[i] = words[i+1];
          n_words--;
        end
      end
      FN_GET: begin
        if (int'(p) >= n_words) r.status = ST_RANGE;
        else r.word = words[p];
      end
      FN_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < n_words; i++) begin
          if (words[i] == w) begin
            r.status = ST_OK;
            r.found  = POS_W'(i);
            break;
          end
        end
      end
      FN_CLEAR: n_words = 0;
      default: ;
    endcase
    r.count = CW'(n_words);
    r.empty = (n_words == 0);
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      err_n++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      n_words = 0;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: result with no item waiting: status %h word %h", $time,
                   status, word_out);
          err_n++;
        end else begin
          want = due_q.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(status));
          check_field("word_out", want.word, word_out);
          check_field("found_at", WORD_W'(want.found), WORD_W'(found_at));
          check_field("count", WORD_W'(want.count), WORD_W'(count));
          check_field("is_empty", WORD_W'(want.empty), WORD_W'(is_empty));
        end
      end
      if (in_valid && !in_stall) due_q.push_back(apply_list_op(func, position, word_in));
    end
    errors  <= err_n;
    pending <= due_q.size();
  end

endmodule

// File: dv/array_list_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_tb: stimulus and verdict for the list table
// Directed items cover empty, full and out-of-range cases of the operations;
// phases of weighted random operations follow under varied idling and stall,
// including a long output hold. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module array_list_table_tb;
  import alt_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NOP = 3'd7;
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;
  localparam int HOLD_LEN   = 400;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        func = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] word_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] word_out;
  logic [POS_W-1:0]         found_at;
  logic [CW-1:0]            count;
  logic                     is_empty;
  int                       errors;
  int                       pending;

  int   send_pct  = 0;
  int   stall_pct = 0;
  logic hold_tog  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int mix_wt [3][7] = '{'{35, 24, 10, 6, 10, 14, 1},
                        '{14, 10, 12, 30, 12, 20, 2},
                        '{22, 16, 12, 18, 12, 18, 2}};

  array_list_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .position  (position),
    .word_in   (word_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .word_out  (word_out),
    .found_at  (found_at),
    .count     (count),
    .is_empty  (is_empty)
  );

  array_list_table_checker list_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .position  (position),
    .word_in   (word_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .word_out  (word_out),
    .found_at  (found_at),
    .count     (count),
    .is_empty  (is_empty),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // hold the output for a long stretch on each toggle, else stall at random
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic [WORD_W-1:0] w);
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    func     <= f;
    position <= p;
    word_in  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_list();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] pool [8] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF,
                                    32'h80000000, 32'h5A5A5A5A, 32'h7, 32'h2A};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int mix);
    int r;
    int acc;
    r   = $urandom_range(0, 99);
    acc = 0;
    for (int k = 0; k < 7; k++) begin
      acc += mix_wt[mix][k];
      if (r < acc) return FUNC_W'(k);
    end
    return FN_GET;
  endfunction

  task automatic run_phase(input int n, input int idle, input int stall, input int mix,
                           input int pos_max, input bit hold);
    send_pct  = idle;
    stall_pct <= stall;
    if (hold) hold_tog <= ~hold_tog;
    repeat (n) send_item(pick_func(mix), POS_W'($urandom_range(0, pos_max)), pick_word());
    drain_list();
  endtask

  task automatic fill_list();
    send_item(FN_CLEAR, '0, '0);
    repeat (DEPTH) send_item(FN_APPEND, '0, pick_word());
    send_item(FN_APPEND, '0, 32'h13579BDF);
    send_item(FN_INSERT, '0, 32'h2468ACE0);
    send_item(FN_INSERT, 6'd63, 32'h2468ACE0);
    send_item(FN_GET, 6'd63, '0);
    send_item(FN_FIND, '0, 32'h7FFFFFFF);
    send_item(FN_REMOVE, 6'd63, '0);
    send_item(FN_INSERT, 6'd63, 32'hC0FFEE00);
    send_item(FN_REMOVE, '0, '0);
    send_item(FN_SET, 6'd63, 32'h1);
    send_item(FN_SET, 6'd62, 32'hFFFFFFFF);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, boundaries, every operation
    send_item(FN_FIND, '0, 32'h0);
    send_item(FN_REMOVE, '0, '0);
    send_item(FN_GET, '0, '0);
    send_item(FN_SET, '0, 32'h1);
    send_item(FN_INSERT, 6'd1, 32'h1);
    send_item(FN_INSERT, '0, 32'h7FFFFFFF);
    send_item(FN_APPEND, '0, 32'h80000000);
    send_item(FN_APPEND, '0, 32'hFFFFFFFF);
    send_item(FN_APPEND, '0, 32'h0);
    send_item(FN_INSERT, 6'd1, 32'h55555555);
    send_item(FN_INSERT, 6'd5, 32'hAAAAAAAA);
    send_item(FN_GET, 6'd63, '0);
    send_item(FN_GET, '0, '0);
    send_item(FN_SET, 6'd4, 32'h12345678);
    send_item(FN_FIND, '0, 32'h80000000);
    send_item(FN_FIND, '0, 32'hFFFFFFFF);
    send_item(FN_FIND, '0, 32'hDEADBEEF);
    send_item(FN_REMOVE, '0, '0);
    send_item(FN_REMOVE, 6'd4, '0);
    send_item(FN_NOP, 6'd2, 32'hFFFFFFFF);
    send_item(FN_CLEAR, '0, '0);
    send_item(FN_GET, '0, '0);
    send_item(FN_FIND, '0, 32'h0);
    drain_list();

    fill_list();
    drain_list();

    run_phase(110, 0, 0, MIX_GROW, 63, 1'b0);
    run_phase(110, 58, 0, MIX_EVEN, 31, 1'b0);
    run_phase(110, 0, 58, MIX_GROW, 63, 1'b1);
    run_phase(110, 22, 22, MIX_SHRINK, 63, 1'b0);
    send_pct = 22;
    fill_list();
    run_phase(90, 0, 0, MIX_EVEN, 7, 1'b0);

    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
